// File: rtl/core/blpm_pkg.sv
// Package: sizes, opcodes and a saturating add helper for the binary lifting core.
package blpm_pkg;

	localparam int Nodes    = 1024;
	localparam int Levels   = 32;
	localparam int NodeW    = $clog2(Nodes);
	localparam int LevelW   = (Levels > 1) ? $clog2(Levels) : 1;
	localparam int AddrW    = $clog2(Levels * Nodes);
	localparam int ValW     = 48;
	localparam int OpW      = 2;

	localparam logic [OpW-1:0] OP_LOAD  = 2'd0;
	localparam logic [OpW-1:0] OP_BUILD = 2'd1;
	localparam logic [OpW-1:0] OP_QUERY = 2'd2;

	localparam logic signed [ValW-1:0] VAL_MAX = {1'b0, {(ValW-1){1'b1}}};
	localparam logic signed [ValW-1:0] VAL_MIN = {1'b1, {(ValW-1){1'b0}}};

	typedef struct packed {
		logic [OpW-1:0]     op;
		logic [9:0]         node;
		logic [9:0]         next_node;
		logic signed [31:0] step_value;
		logic signed [31:0] step_peak;
		logic [31:0]        steps;
	} req_t;

	typedef struct packed {
		logic [9:0]              end_node;
		logic signed [ValW-1:0]  path_sum;
		logic signed [ValW-1:0]  path_peak;
		logic                    empty_res;
	} rsp_t;

	typedef struct packed {
		logic [NodeW-1:0]        target;
		logic signed [ValW-1:0]  sum;
		logic signed [ValW-1:0]  peak;
	} entry_t;

	function automatic logic signed [ValW-1:0] sat_add(
		input logic signed [ValW-1:0] a,
		input logic signed [ValW-1:0] b
	);
		logic signed [ValW:0] s;
		s = {a[ValW-1], a} + {b[ValW-1], b};
		if (s[ValW] != s[ValW-1])
			return s[ValW] ? VAL_MIN : VAL_MAX;
		return s[ValW-1:0];
	endfunction

endpackage

// File: rtl/core/blpm_if.sv
// Interface: valid/ready channel carrying one payload beat.
interface blpm_if #(type payload_t = logic) ();
	logic     valid;
	logic     ready;
	payload_t data;
	modport source (output valid, output data, input ready);
	modport sink (input valid, input data, output ready);
endinterface

// File: rtl/core/binary_lifting_path_monoid_core.sv
// Top level: binary lifting table with load, build and query sequencer.
//
// Channels: in_ch carries request beats (op, node, next_node, step_value,
// step_peak, steps); out_ch carries one result beat per query.
// A load writes the base entry at its accepting edge and gives no result.
// A build walks every node of every level below the top: per entry ST_RDA
// reads level k at the node, ST_RDB reads level k at its successor, and
// ST_WRB combines and writes level k+1. The table's single read port makes
// these steps run one after another.
// A query reads a level (ST_QRD), then combines it (ST_QCMB), for each of
// the Levels bits of steps, and then presents its result.
// Only one request is worked at a time; in_ch.ready is low while busy.
// The result sits in an output register; while the receiver stalls,
// the next request may already be accepted and worked, but the result
// of a second query waits until the first beat is taken.
// Reset clears the sequencer and the output valid; the table itself is
// not cleared, and reading an entry never written gives arbitrary data.
module binary_lifting_path_monoid_core
	import blpm_pkg::*;
(
	input  logic        clk,
	input  logic        arst_n,
	blpm_if.sink        in_ch,
	blpm_if.source      out_ch
);

	typedef enum logic [6:0] {
		ST_IDLE  = 7'b0000001,
		ST_RDA   = 7'b0000010,
		ST_RDB   = 7'b0000100,
		ST_WRB   = 7'b0001000,
		ST_QRD   = 7'b0010000,
		ST_QCMB  = 7'b0100000,
		ST_DONE  = 7'b1000000
	} state_t;

	state_t                  state_q;
	entry_t                  mem [Levels*Nodes];
	entry_t                  rd_q;
	logic [AddrW-1:0]        rd_addr;
	logic                    rd_en;
	logic                    wr_en;
	logic [AddrW-1:0]        wr_addr;
	entry_t                  wr_data;

	logic [LevelW-1:0]       lvl_q;
	logic [NodeW-1:0]        idx_q;
	entry_t                  a_q;
	logic [31:0]             steps_q;
	logic [NodeW-1:0]        pos_q;
	logic signed [ValW-1:0]  sum_q;
	logic signed [ValW-1:0]  peak_q;
	logic                    empty_q;
	rsp_t                    rsp_q;
	logic                    ovalid_q;

	logic signed [ValW-1:0]  mid;
	logic signed [ValW-1:0]  add_a;
	logic signed [ValW-1:0]  add_b;
	logic                    last_lvl;

	function automatic logic [AddrW-1:0] addr_of(
		input logic [LevelW-1:0] l,
		input logic [NodeW-1:0]  n
	);
		logic [AddrW+LevelW-1:0] w;
		w = (AddrW+LevelW)'(l) * (AddrW+LevelW)'(Nodes) + (AddrW+LevelW)'(n);
		return w[AddrW-1:0];
	endfunction

	// one shared saturating adder: peak path in combine states
	always_comb begin
		if (state_q == ST_WRB) begin
			add_a = a_q.sum;
		end else begin
			add_a = sum_q;
		end
		add_b = rd_q.peak;
	end
	assign mid = sat_add(add_a, add_b);
	assign last_lvl = (32'(lvl_q) == 32'(Levels - 1));

	assign in_ch.ready = (state_q == ST_IDLE);
	assign out_ch.valid = ovalid_q;
	assign out_ch.data = rsp_q;

	// table port control
	always_comb begin
		rd_en = 1'b0;
		rd_addr = addr_of(lvl_q, idx_q);
		wr_en = 1'b0;
		wr_addr = addr_of(lvl_q, idx_q);
		wr_data = '0;
		unique case (state_q)
			ST_IDLE: begin
				if (in_ch.valid && in_ch.data.op == OP_LOAD) begin
					wr_en = 1'b1;
					wr_addr = addr_of('0, in_ch.data.node[NodeW-1:0]);
					wr_data.target = in_ch.data.next_node[NodeW-1:0];
					wr_data.sum = ValW'(in_ch.data.step_value);
					wr_data.peak = ValW'(in_ch.data.step_peak);
				end
			end
			ST_RDA: begin
				rd_en = 1'b1;
			end
			ST_RDB: begin
				rd_en = 1'b1;
				rd_addr = addr_of(lvl_q, rd_q.target);
			end
			ST_WRB: begin
				wr_en = 1'b1;
				wr_addr = addr_of(lvl_q + LevelW'(1), idx_q);
				wr_data.target = rd_q.target;
				wr_data.sum = sat_add(a_q.sum, rd_q.sum);
				wr_data.peak = (a_q.peak > mid) ? a_q.peak : mid;
			end
			ST_QRD: begin
				rd_en = 1'b1;
				rd_addr = addr_of(lvl_q, pos_q);
			end
			ST_QCMB: ;
			ST_DONE: ;
			default: ;
		endcase
	end

	always_ff @(posedge clk) begin
		if (wr_en)
			mem[wr_addr] <= wr_data;
		if (rd_en)
			rd_q <= mem[rd_addr];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			ovalid_q <= 1'b0;
			lvl_q <= '0;
			idx_q <= '0;
		end else begin
			// drop the taken beat unless a new result replaces it this cycle
			if (out_ch.valid && out_ch.ready && state_q != ST_DONE)
				ovalid_q <= 1'b0;
			unique case (state_q)
				ST_IDLE: begin
					if (in_ch.valid) begin
						lvl_q <= '0;
						idx_q <= '0;
						priority if (in_ch.data.op == OP_BUILD) begin
							if (Levels > 1)
								state_q <= ST_RDA;
						end else if (in_ch.data.op == OP_QUERY) begin
							state_q <= ST_QRD;
						end else begin
							// load finishes at this edge; spare op is dropped
						end
					end
				end
				ST_RDA: state_q <= ST_RDB;
				ST_RDB: state_q <= ST_WRB;
				ST_WRB: begin
					// advance node, then level
					state_q <= ST_RDA;
					if (32'(idx_q) == 32'(Nodes - 1)) begin
						idx_q <= '0;
						if (32'(lvl_q) + 1 == 32'(Levels - 1))
							state_q <= ST_IDLE;
						else
							lvl_q <= lvl_q + LevelW'(1);
					end else begin
						idx_q <= idx_q + NodeW'(1);
					end
				end
				ST_QRD: state_q <= ST_QCMB;
				ST_QCMB: begin
					if (last_lvl || 32'(lvl_q) == 31) begin
						state_q <= ST_DONE;
					end else begin
						lvl_q <= lvl_q + LevelW'(1);
						state_q <= ST_QRD;
					end
				end
				ST_DONE: begin
					// hold until the output register is free
					if (!ovalid_q || out_ch.ready) begin
						ovalid_q <= 1'b1;
						state_q <= ST_IDLE;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	// datapath registers
	always_ff @(posedge clk) begin
		if (state_q == ST_IDLE && in_ch.valid) begin
			steps_q <= in_ch.data.steps;
			pos_q <= in_ch.data.node[NodeW-1:0];
			sum_q <= '0;
			peak_q <= VAL_MIN;
			empty_q <= (in_ch.data.steps == '0);
		end
		if (state_q == ST_RDB)
			a_q <= rd_q;
		if (state_q == ST_QCMB && steps_q[lvl_q[LevelW-1:0] % 32]) begin
			if (mid > peak_q)
				peak_q <= mid;
			sum_q <= sat_add(sum_q, rd_q.sum);
			pos_q <= rd_q.target;
		end
		if (state_q == ST_DONE && (!ovalid_q || out_ch.ready)) begin
			rsp_q.end_node <= 10'(pos_q);
			rsp_q.path_sum <= sum_q;
			rsp_q.path_peak <= peak_q;
			rsp_q.empty_res <= empty_q;
		end
	end

endmodule

// File: test/tb.sv
// Testbench for the binary lifting core: load, build and query traffic against an internal predictor.
`timescale 1ns / 100ps

module tb;
	import blpm_pkg::*;

	localparam logic [OpW-1:0] OP_SPARE = 2'd3;
	localparam int WATCHDOG = 400000;
	localparam int LONG_HOLD = 300;
	localparam longint S48_TOP = 64'sh0000_7FFF_FFFF_FFFF;
	localparam longint S48_BOT = -S48_TOP - 1;

	logic clk = 1'b0;
	logic arst_n = 1'b0;

	blpm_if #(.payload_t(req_t)) in_ch ();
	blpm_if #(.payload_t(rsp_t)) out_ch ();

	binary_lifting_path_monoid_core dut (
		.clk    (clk),
		.arst_n (arst_n),
		.in_ch  (in_ch),
		.out_ch (out_ch)
	);

	always #2 clk = ~clk;

	// Shadow of the jump table, indexed by level*Nodes + node.
	logic [NodeW-1:0] hop_to [Levels*Nodes];
	longint           hop_sum [Levels*Nodes];
	longint           hop_peak [Levels*Nodes];

	rsp_t walk_results [$];
	int   errors = 0;
	bit   gaps_on = 1'b1;
	bit   long_hold_req = 1'b0;
	int   hold_left = 0;
	int   stall_left = 0;
	int   quiet_cycles = 0;

	function automatic longint sat48(longint a, longint b);
		longint s;
		s = a + b;
		if (s > S48_TOP)
			return S48_TOP;
		if (s < S48_BOT)
			return S48_BOT;
		return s;
	endfunction

	function automatic longint sx48(logic [ValW-1:0] v);
		return longint'(signed'(v));
	endfunction

	// Double every level: level k+1 is level k here, then level k at the successor.
	function automatic void double_levels();
		int a, b, d;
		longint mid;
		for (int k = 0; k + 1 < Levels; k++) begin
			for (int i = 0; i < Nodes; i++) begin
				a = k * Nodes + i;
				b = k * Nodes + hop_to[a];
				d = (k + 1) * Nodes + i;
				mid = sat48(hop_sum[a], hop_peak[b]);
				hop_to[d] = hop_to[b];
				hop_peak[d] = (hop_peak[a] > mid) ? hop_peak[a] : mid;
				hop_sum[d] = sat48(hop_sum[a], hop_sum[b]);
			end
		end
	endfunction

	// Walk the set bits of steps, lowest first, combining one level per bit.
	function automatic rsp_t walk_path(logic [9:0] start, logic [31:0] steps);
		rsp_t r;
		logic [NodeW-1:0] pos;
		longint sum, peak, mid;
		int e;
		pos = start;
		sum = 0;
		peak = S48_BOT;
		for (int b = 0; b < Levels && b < 32; b++) begin
			if (steps[b]) begin
				e = b * Nodes + pos;
				mid = sat48(sum, hop_peak[e]);
				if (mid > peak)
					peak = mid;
				sum = sat48(sum, hop_sum[e]);
				pos = hop_to[e];
			end
		end
		r.end_node = pos;
		r.path_sum = sum[ValW-1:0];
		r.path_peak = peak[ValW-1:0];
		r.empty_res = (steps == 0);
		return r;
	endfunction

	function automatic void track_beat(req_t q);
		case (q.op)
			OP_LOAD: begin
				hop_to[q.node] = q.next_node;
				hop_sum[q.node] = longint'(q.step_value);
				hop_peak[q.node] = longint'(q.step_peak);
			end
			OP_BUILD: double_levels();
			OP_QUERY: walk_results.push_back(walk_path(q.node, q.steps));
			default: ;
		endcase
	endfunction

	task automatic report(string what, longint got, longint want);
		$display("MISMATCH %s: got %0d expected %0d at %0t", what, got, want, $realtime);
		errors++;
	endtask

	// Offer one beat; hold valid until it is taken, then maybe idle a short burst.
	task automatic send_beat(req_t q);
		in_ch.valid <= 1'b1;
		in_ch.data <= q;
		do @(posedge clk); while (!in_ch.ready);
		track_beat(q);
		if (gaps_on && $urandom_range(0, 5) == 0) begin
			in_ch.valid <= 1'b0;
			repeat ($urandom_range(1, 4)) @(posedge clk);
		end
	endtask

	function automatic req_t load_beat(logic [9:0] n, logic [9:0] nx, logic [31:0] v,
		logic [31:0] p);
		req_t q;
		q = '0;
		q.op = OP_LOAD;
		q.node = n;
		q.next_node = nx;
		q.step_value = v;
		q.step_peak = p;
		return q;
	endfunction

	function automatic req_t walk_beat(logic [9:0] n, logic [31:0] s);
		req_t q;
		q = req_t'($urandom);
		q.op = OP_QUERY;
		q.node = n;
		q.steps = s;
		return q;
	endfunction

	function automatic req_t build_beat();
		req_t q;
		q = req_t'($urandom);
		q.op = OP_BUILD;
		return q;
	endfunction

	function automatic logic [31:0] random_steps();
		case ($urandom_range(0, 4))
			0: return $urandom;
			1: return $urandom_range(0, 15);
			2: return 32'd1 << $urandom_range(0, 31);
			3: return ~(32'd1 << $urandom_range(0, 31));
			default: return $urandom & $urandom;
		endcase
	endfunction

	// Fill every base entry so no build or walk ever reads an unwritten entry.
	// Self loops at the value extremes drive the sums into saturation.
	task automatic test_load_all();
		for (int i = 0; i < Nodes; i++) begin
			case (i)
				0: send_beat(load_beat(10'd0, 10'd1023, 32'h7FFF_FFFF, 32'h8000_0000));
				1023: send_beat(load_beat(10'd1023, 10'd0, 32'h8000_0000, 32'h7FFF_FFFF));
				5: send_beat(load_beat(10'd5, 10'd5, 32'h7FFF_FFFF, 32'h7FFF_FFFF));
				6: send_beat(load_beat(10'd6, 10'd6, 32'h8000_0000, 32'h8000_0000));
				default: send_beat(load_beat(10'(i), 10'($urandom), $urandom, $urandom));
			endcase
		end
	endtask

	task automatic test_directed_walks();
		send_beat(build_beat());
		send_beat(walk_beat(10'd0, 32'd0));
		send_beat(walk_beat(10'd1023, 32'd0));
		send_beat(walk_beat(10'd0, 32'd1));
		send_beat(walk_beat(10'd1023, 32'd1));
		send_beat(walk_beat(10'd0, 32'hFFFF_FFFF));
		send_beat(walk_beat(10'd1023, 32'hFFFF_FFFF));
		send_beat(walk_beat(10'd5, 32'hFFFF_FFFF));
		send_beat(walk_beat(10'd5, 32'h8000_0000));
		send_beat(walk_beat(10'd6, 32'hFFFF_FFFF));
		send_beat(walk_beat(10'd6, 32'h0001_0000));
		send_beat(walk_beat(10'd1023, 32'h8000_0000));
		send_beat(walk_beat(10'h2AA, 32'h5555_5555));
		send_beat(walk_beat(10'h155, 32'hAAAA_AAAA));
		begin
			req_t q;
			q = req_t'($urandom);
			q.op = OP_SPARE;
			send_beat(q);
		end
		send_beat(walk_beat(10'd7, 32'd3));
	endtask

	// Mixed traffic; rare rebuilds fold newer base entries into the upper levels.
	task automatic test_random_mix(int count);
		int pick, builds;
		req_t q;
		builds = 0;
		for (int i = 0; i < count; i++) begin
			if (i % 100 == 0)
				gaps_on = (i % 300 != 200);
			pick = $urandom_range(0, 99);
			if (pick < 55)
				send_beat(walk_beat(10'($urandom), random_steps()));
			else if (pick < 93)
				send_beat(load_beat(10'($urandom), 10'($urandom), $urandom, $urandom));
			else if (pick < 99 || builds >= 2) begin
				q = req_t'($urandom);
				q.op = OP_SPARE;
				send_beat(q);
			end else begin
				send_beat(build_beat());
				builds++;
			end
		end
		gaps_on = 1'b1;
	endtask

	// Hold the receiver off for a long stretch while queries keep coming.
	task automatic test_backpressure();
		long_hold_req = 1'b1;
		for (int i = 0; i < 8; i++)
			send_beat(walk_beat(10'($urandom), $urandom));
	endtask

	task automatic test_no_idle(int count);
		gaps_on = 1'b0;
		for (int i = 0; i < count; i++)
			send_beat(walk_beat(10'($urandom), random_steps()));
	endtask

	// Result side: check each taken beat, then pick the ready level for the next edge.
	always @(posedge clk) begin
		if (out_ch.valid && out_ch.ready) begin
			if (walk_results.size() == 0) begin
				$display("MISMATCH unexpected result beat at %0t", $realtime);
				errors++;
			end else begin
				rsp_t w;
				w = walk_results.pop_front();
				if (out_ch.data.end_node !== w.end_node)
					report("end_node", out_ch.data.end_node, w.end_node);
				if (out_ch.data.path_sum !== w.path_sum)
					report("path_sum", sx48(out_ch.data.path_sum), sx48(w.path_sum));
				if (out_ch.data.path_peak !== w.path_peak)
					report("path_peak", sx48(out_ch.data.path_peak), sx48(w.path_peak));
				if (out_ch.data.empty_res !== w.empty_res)
					report("empty_res", out_ch.data.empty_res, w.empty_res);
			end
		end
		if ((out_ch.valid && out_ch.ready) || (in_ch.valid && in_ch.ready))
			quiet_cycles = 0;
		else
			quiet_cycles++;
		if (quiet_cycles >= WATCHDOG) begin
			$display("Some tests failed");
			$finish;
		end
		if (long_hold_req) begin
			long_hold_req = 1'b0;
			hold_left = LONG_HOLD;
		end
		if (hold_left > 0) begin
			out_ch.ready <= 1'b0;
			hold_left--;
		end else if (stall_left > 0) begin
			out_ch.ready <= 1'b0;
			stall_left--;
		end else if (gaps_on && $urandom_range(0, 6) == 0) begin
			out_ch.ready <= 1'b0;
			stall_left = $urandom_range(1, 4) - 1;
		end else
			out_ch.ready <= 1'b1;
	end

	initial begin
		in_ch.valid = 1'b0;
		in_ch.data = '0;
		out_ch.ready = 1'b0;
		repeat (8) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_load_all();
		test_directed_walks();
		test_random_mix(540);
		test_backpressure();
		test_no_idle(60);
		in_ch.valid <= 1'b0;
		while (walk_results.size() != 0)
			@(posedge clk);
		repeat (150) @(posedge clk);
		if (errors == 0)
			$display("All tests passed");
		else
			$display("Some tests failed");
		$finish;
	end

endmodule
